### hdl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Types and constants shared by the point-in-triangle test.
// ----------------------------------------------------------------------------
package pit_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int CFG_WIDTH   = 3 * COORD_WIDTH;
	localparam int CFG_IDX_W   = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CORNER_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CORNER_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CORNER_C = 2'd2;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] point_z;
		logic                          quadrant_mode;
	} query_t;

	typedef struct packed {
		logic       inside_res;
		logic       degenerate;
		logic [1:0] dropped_axis;
	} result_t;

endpackage

### hdl/point_in_triangle_test.sv
// One query point enters per clock: a transaction is taken at every edge where
// start is high, and busy is always low. Each query produces exactly one result,
// flagged by done for one cycle; results leave in query order and cannot be held
// off. Each query runs through the nine-stage pipeline (normal, axis selection,
// projected cross products), with a register after every multiply. Corners are
// written through the cfg port; the user must write them only while no query is
// in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
// point_in_triangle_test
// Pipelined exact-integer point-in-triangle test against a 3D triangle held
// in three corner registers; drops the dominant normal axis and decides the
// barycentric test with 2D cross products.
// ----------------------------------------------------------------------------
module point_in_triangle_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  pit_pkg::query_t                     query,
	output logic                                done,
	output pit_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [pit_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [pit_pkg::CFG_WIDTH-1:0]       cfg_data
);

	localparam int CW = pit_pkg::COORD_WIDTH;
	localparam int EW = CW + 1;          // coordinate difference
	localparam int PW = 2 * EW;          // product of two differences
	localparam int NW = PW + 1;          // difference of two products
	localparam int DW = NW + 1;          // s2 - s1

	logic [pit_pkg::CFG_WIDTH-1:0] corner_a_q, corner_b_q, corner_c_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	// stage 1: captured corners and point
	logic signed [CW-1:0] a_s1 [3];
	logic signed [CW-1:0] b_s1 [3];
	logic signed [CW-1:0] c_s1 [3];
	logic signed [CW-1:0] p_s1 [3];
	logic                 quad_s1;

	// stage 2: edge vectors, e[0] = C-A, e[1] = B-A, e[2] = P-A
	logic signed [EW-1:0] u_s2 [3];
	logic signed [EW-1:0] w_s2 [3];
	logic signed [EW-1:0] e_s2 [3][3];
	logic                 quad_s2;

	// stage 3: normal partial products
	logic signed [PW-1:0] m_s3 [6];
	logic signed [EW-1:0] e_s3 [3][3];
	logic                 quad_s3;

	// stage 4: normal
	logic signed [NW-1:0] n_s4 [3];
	logic signed [EW-1:0] e_s4 [3][3];
	logic                 quad_s4;

	// stage 5: dropped axis
	pit_pkg::axis_t       axis_s5;
	logic signed [EW-1:0] e_s5 [3][3];
	logic                 quad_s5;

	// stage 6: projected vectors, [vector][0 = first kept axis, 1 = second]
	logic signed [EW-1:0] q_s6 [3][2];
	pit_pkg::axis_t       axis_s6;
	logic                 quad_s6;

	// stage 7: cross product terms
	logic signed [PW-1:0] x_s7 [6];
	pit_pkg::axis_t       axis_s7;
	logic                 quad_s7;

	// stage 8: cross products
	logic signed [NW-1:0] d_s8, s1_s8, s2_s8;
	pit_pkg::axis_t       axis_s8;
	logic                 quad_s8;

	// stage 9: output
	pit_pkg::result_t     res_s9;

	logic                 accept;
	logic [NW-1:0]        nabs [3];
	pit_pkg::axis_t       axis_nxt;
	logic [1:0]           k0, k1;
	logic signed [DW-1:0] diff;
	logic                 inside_nxt;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_a_q <= '0;
			corner_b_q <= '0;
			corner_c_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				pit_pkg::REG_CORNER_A: corner_a_q <= cfg_data;
				pit_pkg::REG_CORNER_B: corner_b_q <= cfg_data;
				pit_pkg::REG_CORNER_C: corner_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nabs[i] = n_s4[i][NW-1] ? NW'(-n_s4[i]) : NW'(n_s4[i]);
		end
		if (nabs[0] > nabs[1] && nabs[0] > nabs[2]) begin
			axis_nxt = pit_pkg::AXIS_X;
		end else if (nabs[1] > nabs[2]) begin
			axis_nxt = pit_pkg::AXIS_Y;
		end else begin
			axis_nxt = pit_pkg::AXIS_Z;
		end
	end

	always_comb begin
		case (axis_s5)
			pit_pkg::AXIS_X: begin
				k0 = 2'd1;
				k1 = 2'd2;
			end
			pit_pkg::AXIS_Y: begin
				k0 = 2'd0;
				k1 = 2'd2;
			end
			default: begin
				k0 = 2'd0;
				k1 = 2'd1;
			end
		endcase
	end

	always_comb begin
		diff = DW'(s2_s8) - DW'(s1_s8);
		if (d_s8[NW-1]) begin
			inside_nxt = (s1_s8 > 0) && (s2_s8 < 0) && (quad_s8 || diff > DW'(d_s8));
		end else begin
			inside_nxt = (s1_s8 < 0) && (s2_s8 > 0) && (quad_s8 || diff < DW'(d_s8));
		end
	end

	always_ff @(posedge clk) begin
		// stage 1
		a_s1[0] <= $signed(corner_a_q[CW-1:0]);
		a_s1[1] <= $signed(corner_a_q[2*CW-1:CW]);
		a_s1[2] <= $signed(corner_a_q[3*CW-1:2*CW]);
		b_s1[0] <= $signed(corner_b_q[CW-1:0]);
		b_s1[1] <= $signed(corner_b_q[2*CW-1:CW]);
		b_s1[2] <= $signed(corner_b_q[3*CW-1:2*CW]);
		c_s1[0] <= $signed(corner_c_q[CW-1:0]);
		c_s1[1] <= $signed(corner_c_q[2*CW-1:CW]);
		c_s1[2] <= $signed(corner_c_q[3*CW-1:2*CW]);
		p_s1[0] <= query.point_x;
		p_s1[1] <= query.point_y;
		p_s1[2] <= query.point_z;
		quad_s1 <= query.quadrant_mode;

		// stage 2
		for (int i = 0; i < 3; i++) begin
			u_s2[i]    <= EW'(a_s1[i]) - EW'(c_s1[i]);
			w_s2[i]    <= EW'(b_s1[i]) - EW'(c_s1[i]);
			e_s2[0][i] <= EW'(c_s1[i]) - EW'(a_s1[i]);
			e_s2[1][i] <= EW'(b_s1[i]) - EW'(a_s1[i]);
			e_s2[2][i] <= EW'(p_s1[i]) - EW'(a_s1[i]);
		end
		quad_s2 <= quad_s1;

		// stage 3
		m_s3[0] <= PW'(u_s2[1]) * PW'(w_s2[2]);
		m_s3[1] <= PW'(u_s2[2]) * PW'(w_s2[1]);
		m_s3[2] <= PW'(u_s2[2]) * PW'(w_s2[0]);
		m_s3[3] <= PW'(u_s2[0]) * PW'(w_s2[2]);
		m_s3[4] <= PW'(u_s2[0]) * PW'(w_s2[1]);
		m_s3[5] <= PW'(u_s2[1]) * PW'(w_s2[0]);
		e_s3    <= e_s2;
		quad_s3 <= quad_s2;

		// stage 4
		n_s4[0] <= NW'(m_s3[0]) - NW'(m_s3[1]);
		n_s4[1] <= NW'(m_s3[2]) - NW'(m_s3[3]);
		n_s4[2] <= NW'(m_s3[4]) - NW'(m_s3[5]);
		e_s4    <= e_s3;
		quad_s4 <= quad_s3;

		// stage 5
		axis_s5 <= axis_nxt;
		e_s5    <= e_s4;
		quad_s5 <= quad_s4;

		// stage 6
		for (int j = 0; j < 3; j++) begin
			q_s6[j][0] <= e_s5[j][k0];
			q_s6[j][1] <= e_s5[j][k1];
		end
		axis_s6 <= axis_s5;
		quad_s6 <= quad_s5;

		// stage 7
		x_s7[0] <= PW'(q_s6[0][0]) * PW'(q_s6[1][1]);
		x_s7[1] <= PW'(q_s6[0][1]) * PW'(q_s6[1][0]);
		x_s7[2] <= PW'(q_s6[1][0]) * PW'(q_s6[2][1]);
		x_s7[3] <= PW'(q_s6[1][1]) * PW'(q_s6[2][0]);
		x_s7[4] <= PW'(q_s6[0][0]) * PW'(q_s6[2][1]);
		x_s7[5] <= PW'(q_s6[0][1]) * PW'(q_s6[2][0]);
		axis_s7 <= axis_s6;
		quad_s7 <= quad_s6;

		// stage 8
		d_s8    <= NW'(x_s7[0]) - NW'(x_s7[1]);
		s1_s8   <= NW'(x_s7[2]) - NW'(x_s7[3]);
		s2_s8   <= NW'(x_s7[4]) - NW'(x_s7[5]);
		axis_s8 <= axis_s7;
		quad_s8 <= quad_s7;

		// stage 9
		res_s9.degenerate   <= (d_s8 == '0);
		res_s9.inside_res   <= (d_s8 != '0) && inside_nxt;
		res_s9.dropped_axis <= axis_s8;
	end

	assign done   = v_s9;
	assign result = res_s9;

endmodule

### tb/pit_checker.sv
// ----------------------------------------------------------------------------
// pit_checker
// Watches the query, result and corner-write channels of the point-in-triangle
// test, predicts each result from its own copy of the corners and compares
// every result field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module pit_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  pit_pkg::query_t               query,
	input  logic                          done,
	input  pit_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [pit_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [pit_pkg::CFG_WIDTH-1:0] cfg_data,
	output int                            mismatches,
	output int                            in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = pit_pkg::COORD_WIDTH;
	localparam int FW = pit_pkg::CFG_WIDTH;

	logic [FW-1:0] corner_a, corner_b, corner_c;
	pit_pkg::result_t verdict_q[$];

	function automatic longint coord(logic [FW-1:0] packed_xyz, int k);
		logic signed [CW-1:0] c;
		c = packed_xyz[k*CW +: CW];
		return longint'(c);
	endfunction

	function automatic pit_pkg::result_t classify_point(pit_pkg::query_t q,
			logic [FW-1:0] ra, logic [FW-1:0] rb, logic [FW-1:0] rc);
		longint a[3], b[3], c[3], p[3], n[3], m[3];
		longint ax, ay, bx, by, cx, cy, px, py;
		longint d, s1, s2;
		int i0, i1;
		pit_pkg::result_t r;
		for (int k = 0; k < 3; k++) begin
			a[k] = coord(ra, k);
			b[k] = coord(rb, k);
			c[k] = coord(rc, k);
		end
		p[0] = longint'(q.point_x);
		p[1] = longint'(q.point_y);
		p[2] = longint'(q.point_z);
		// normal of (A-C) x (B-C)
		n[0] = (a[1]-c[1])*(b[2]-c[2]) - (a[2]-c[2])*(b[1]-c[1]);
		n[1] = (a[2]-c[2])*(b[0]-c[0]) - (a[0]-c[0])*(b[2]-c[2]);
		n[2] = (a[0]-c[0])*(b[1]-c[1]) - (a[1]-c[1])*(b[0]-c[0]);
		for (int k = 0; k < 3; k++)
			m[k] = (n[k] < 0) ? -n[k] : n[k];
		if (m[0] > m[1] && m[0] > m[2]) begin
			r.dropped_axis = pit_pkg::AXIS_X;
			i0 = 1;
			i1 = 2;
		end else if (m[1] > m[2]) begin
			r.dropped_axis = pit_pkg::AXIS_Y;
			i0 = 0;
			i1 = 2;
		end else begin
			r.dropped_axis = pit_pkg::AXIS_Z;
			i0 = 0;
			i1 = 1;
		end
		ax = a[i0]; ay = a[i1];
		bx = b[i0]; by = b[i1];
		cx = c[i0]; cy = c[i1];
		px = p[i0]; py = p[i1];
		d  = (cx-ax)*(by-ay) - (cy-ay)*(bx-ax);
		s1 = (bx-ax)*(py-ay) - (by-ay)*(px-ax);
		s2 = (cx-ax)*(py-ay) - (cy-ay)*(px-ax);
		r.inside_res = 1'b0;
		r.degenerate = (d == 0);
		if (d != 0) begin
			if (d < 0) begin
				d  = -d;
				s1 = -s1;
				s2 = -s2;
			end
			r.inside_res = (s1 < 0) && (s2 > 0) && (q.quadrant_mode || (s2 - s1 < d));
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pit_pkg::result_t want;
		if (!arst_n) begin
			corner_a   = '0;
			corner_b   = '0;
			corner_c   = '0;
			mismatches = 0;
			in_flight  = 0;
			verdict_q.delete();
		end else begin
			if (done) begin
				if (verdict_q.size() == 0) begin
					mismatches++;
					$display("%0t: expected none, got inside=%0d degen=%0d axis=%0d",
						$time, result.inside_res, result.degenerate,
						result.dropped_axis);
				end else begin
					want = verdict_q.pop_front();
					if (result.inside_res !== want.inside_res) begin
						mismatches++;
						$display("%0t: inside_res expected %0d got %0d",
							$time, want.inside_res, result.inside_res);
					end
					if (result.degenerate !== want.degenerate) begin
						mismatches++;
						$display("%0t: degenerate expected %0d got %0d",
							$time, want.degenerate, result.degenerate);
					end
					if (result.dropped_axis !== want.dropped_axis) begin
						mismatches++;
						$display("%0t: dropped_axis expected %0d got %0d",
							$time, want.dropped_axis, result.dropped_axis);
					end
				end
			end
			// a transaction sees the corners as they stood before this edge
			if (start && !busy)
				verdict_q.insert(verdict_q.size(),
					classify_point(query, corner_a, corner_b, corner_c));
			if (cfg_we) begin
				case (cfg_idx)
					pit_pkg::REG_CORNER_A: corner_a = cfg_data;
					pit_pkg::REG_CORNER_B: corner_b = cfg_data;
					pit_pkg::REG_CORNER_C: corner_c = cfg_data;
					default: ;
				endcase
			end
			in_flight = verdict_q.size();
		end
	end

endmodule

### tb/point_in_triangle_test_tb.sv
// ----------------------------------------------------------------------------
// point_in_triangle_test_tb
// Drives the point-in-triangle test with directed corner cases (degenerate,
// edge and hypotenuse points, each dropped axis, extreme coordinates) and
// then with random triangles and points biased toward the triangle, under
// varying start gaps; the checker module predicts and compares.
// ----------------------------------------------------------------------------
module point_in_triangle_test_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW          = pit_pkg::COORD_WIDTH;
	localparam int FW          = pit_pkg::CFG_WIDTH;
	localparam int IW          = pit_pkg::CFG_IDX_W;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN       = 12;
	localparam int PHASES      = 16;
	localparam int PER_PHASE   = 100;
	localparam logic [IW-1:0] REG_SPARE = 2'd3;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	pit_pkg::query_t  query;
	logic             done;
	pit_pkg::result_t result;
	logic             cfg_we;
	logic [IW-1:0]    cfg_idx;
	logic [FW-1:0]    cfg_data;
	int               mismatches;
	int               in_flight;
	int               cycles;
	int               vert[9];

	point_in_triangle_test dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.query    (query),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	pit_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.query      (query),
		.done       (done),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT)
			@(posedge clk) cycles++;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [FW-1:0] pack_corner(int x, int y, int z);
		return {CW'(z), CW'(y), CW'(x)};
	endfunction

	task automatic write_reg(logic [IW-1:0] idx, logic [FW-1:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
	endtask

	task automatic load_triangle(int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz);
		vert[0] = ax; vert[1] = ay; vert[2] = az;
		vert[3] = bx; vert[4] = by; vert[5] = bz;
		vert[6] = cx; vert[7] = cy; vert[8] = cz;
		write_reg(pit_pkg::REG_CORNER_A, pack_corner(ax, ay, az));
		write_reg(pit_pkg::REG_CORNER_B, pack_corner(bx, by, bz));
		write_reg(pit_pkg::REG_CORNER_C, pack_corner(cx, cy, cz));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_point(int x, int y, int z, bit qm, int gap_pct);
		pit_pkg::query_t q;
		if ($urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end
		q.point_x       = CW'(x);
		q.point_y       = CW'(y);
		q.point_z       = CW'(z);
		q.quadrant_mode = qm;
		@(negedge clk);
		start <= 1'b1;
		query <= q;
		do @(posedge clk); while (busy);
	endtask

	// stop issuing and let every outstanding transaction retire
	task automatic end_phase();
		@(negedge clk);
		start <= 1'b0;
		while (in_flight != 0) @(negedge clk);
	endtask

	task automatic random_triangle();
		int kind, span, ax, k;
		int v[9];
		kind = $urandom_range(0, 9);
		span = $urandom_range(4, 400);
		if (kind < 3) begin
			for (int i = 0; i < 9; i++)
				v[i] = int'($urandom_range(0, 65535)) - 32768;
		end else if (kind < 9) begin
			for (int i = 0; i < 3; i++)
				v[i] = int'($urandom_range(0, 60000)) - 30000;
			for (int i = 3; i < 9; i++)
				v[i] = v[i % 3] + int'($urandom_range(0, 2 * span)) - span;
			for (int i = 0; i < 3; i++)
				v[i] = v[i] + int'($urandom_range(0, 2 * span)) - span;
			if (kind >= 7) begin
				// flat in one axis
				ax = $urandom_range(0, 2);
				v[3 + ax] = v[ax];
				v[6 + ax] = v[ax];
			end
		end else begin
			// collinear corners
			k = int'($urandom_range(0, 6)) - 3;
			for (int i = 0; i < 3; i++) begin
				v[i]     = int'($urandom_range(0, 20000)) - 10000;
				v[3 + i] = v[i] + int'($urandom_range(0, 100)) - 50;
				v[6 + i] = v[i] + k * (v[3 + i] - v[i]);
			end
		end
		load_triangle(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
	endtask

	task automatic random_point(int gap_pct);
		int sel, w0, w1, w2, wsum;
		int p[3];
		longint acc;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			for (int k = 0; k < 3; k++)
				p[k] = int'($urandom_range(0, 65535)) - 32768;
		end else begin
			w0 = $urandom_range(0, 64);
			w1 = $urandom_range(0, 64);
			w2 = $urandom_range(0, 64);
			wsum = w0 + w1 + w2;
			if (wsum == 0) begin
				w0   = 1;
				wsum = 1;
			end
			for (int k = 0; k < 3; k++) begin
				acc = longint'(w0) * vert[k] + longint'(w1) * vert[3 + k]
					+ longint'(w2) * vert[6 + k];
				p[k] = int'(acc / wsum);
				if (sel >= 80)
					p[k] = p[k] + int'($urandom_range(0, 4)) - 2;
			end
		end
		send_point(p[0], p[1], p[2], 1'($urandom_range(0, 1)), gap_pct);
	endtask

	initial begin
		int gap_pct;
		arst_n   = 1'b0;
		start    = 1'b0;
		query    = '0;
		cfg_we   = 1'b0;
		cfg_idx  = '0;
		cfg_data = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// corners at reset: zero normal
		send_point(-32768, 32767, 0, 1'b0, 0);
		send_point(32767, -32768, -1, 1'b1, 0);
		end_phase();
		write_reg(REG_SPARE, '1);
		@(negedge clk);
		cfg_we <= 1'b0;
		send_point(1, 2, 3, 1'b0, 0);
		end_phase();

		// xy plane: inside, edge, hypotenuse, quadrant, extremes
		load_triangle(0, 0, 0, 100, 0, 0, 0, 100, 0);
		send_point(10, 10, 5, 1'b0, 0);
		send_point(0, 50, 0, 1'b0, 0);
		send_point(50, 50, 0, 1'b0, 0);
		send_point(50, 50, 0, 1'b1, 0);
		send_point(60, 60, -7, 1'b0, 0);
		send_point(60, 60, -7, 1'b1, 0);
		send_point(-1, 10, 0, 1'b1, 0);
		send_point(32767, 32767, -32768, 1'b1, 0);
		send_point(32767, 32767, -32768, 1'b0, 0);
		end_phase();

		load_triangle(5, 0, 0, 5, 100, 0, 5, 0, 100);
		send_point(-32768, 10, 10, 1'b0, 0);
		send_point(32767, -10, 10, 1'b0, 0);
		end_phase();

		load_triangle(0, 7, 0, 100, 7, 0, 0, 7, 100);
		send_point(10, -32768, 10, 1'b0, 0);
		end_phase();

		// |nx| == |ny| > |nz|
		load_triangle(0, 0, 0, 100, -100, 0, 0, 0, 100);
		send_point(10, -10, 10, 1'b0, 0);
		end_phase();

		load_triangle(-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 0);
		send_point(0, 0, 0, 1'b0, 0);
		send_point(-32768, -32768, -32768, 1'b1, 0);
		send_point(32767, 32767, 32767, 1'b0, 0);
		send_point(-32767, -32767, 0, 1'b0, 0);
		end_phase();

		load_triangle(0, 0, 0, 10, 20, 30, 20, 40, 60);
		send_point(10, 20, 30, 1'b1, 0);
		end_phase();

		for (int ph = 0; ph < PHASES; ph++) begin
			gap_pct = (ph < 6) ? 9 : (ph < 11) ? 54 : 0;
			random_triangle();
			repeat (PER_PHASE) random_point(gap_pct);
			end_phase();
		end

		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### point_in_triangle_test.f
hdl/pit_pkg.sv
hdl/point_in_triangle_test.sv
tb/pit_checker.sv
tb/point_in_triangle_test_tb.sv
